// ===== design/fbde_pkg.sv =====
package fbde_pkg;

  localparam int FB_WIDTH_DEF  = 256;
  localparam int FB_HEIGHT_DEF = 128;

  // internal coordinate width, wide enough for xa + xb and Bresenham error terms
  localparam int CW = 16;
  typedef logic signed [CW-1:0] coord_t;

  localparam logic [3:0] OP_CLEAR  = 4'd0;
  localparam logic [3:0] OP_POINT  = 4'd1;
  localparam logic [3:0] OP_HSPAN  = 4'd2;
  localparam logic [3:0] OP_VSPAN  = 4'd3;
  localparam logic [3:0] OP_LINE   = 4'd4;
  localparam logic [3:0] OP_RECT   = 4'd5;
  localparam logic [3:0] OP_FILL   = 4'd6;
  localparam logic [3:0] OP_BORDER = 4'd7;
  localparam logic [3:0] OP_READ   = 4'd8;

  typedef enum logic [3:0] {
    J_NONE,
    J_CLEAR,
    J_POINT,
    J_HSPAN,
    J_VSPAN,
    J_LINE,
    J_FILL,
    J_INNER,
    J_TOP,
    J_BOT,
    J_LEFT,
    J_RIGHT,
    J_READ
  } job_sel_t;

  typedef struct packed {
    logic     load;
    logic     start;
    job_sel_t sel;
    logic     out_load;
  } ctl_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

// ===== design/fbde_ram.sv =====
module fbde_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 32768
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end

endmodule

// ===== design/fbde_ctrl.sv =====
module fbde_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [3:0]    in_operation,
  output logic          out_valid,
  input  logic          out_stall,
  output fbde_pkg::ctl_t ctl,
  input  fbde_pkg::sts_t sts
);
  import fbde_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_BUSY,
    ST_FINISH
  } state_t;

  state_t     state_r;
  logic [3:0] op_r;
  logic [2:0] step_r;
  logic       out_valid_r;
  job_sel_t   job;
  logic       accept;

  function automatic job_sel_t job_of(logic [3:0] op, logic [2:0] step);
    job_sel_t j;
    j = J_NONE;
    case (op)
      OP_RECT: begin
        case (step)
          3'd0:    j = J_TOP;
          3'd1:    j = J_BOT;
          3'd2:    j = J_LEFT;
          3'd3:    j = J_RIGHT;
          default: j = J_NONE;
        endcase
      end
      OP_BORDER: begin
        case (step)
          3'd0:    j = J_INNER;
          3'd1:    j = J_TOP;
          3'd2:    j = J_BOT;
          3'd3:    j = J_LEFT;
          3'd4:    j = J_RIGHT;
          default: j = J_NONE;
        endcase
      end
      default: begin
        if (step == 3'd0) begin
          case (op)
            OP_CLEAR: j = J_CLEAR;
            OP_POINT: j = J_POINT;
            OP_HSPAN: j = J_HSPAN;
            OP_VSPAN: j = J_VSPAN;
            OP_LINE:  j = J_LINE;
            OP_FILL:  j = J_FILL;
            OP_READ:  j = J_READ;
            default:  j = J_NONE;
          endcase
        end
      end
    endcase
    return j;
  endfunction

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign job       = job_of(op_r, step_r);

  always_comb begin
    ctl.load     = accept;
    ctl.start    = (state_r == ST_ISSUE) && (job != J_NONE);
    ctl.sel      = job;
    ctl.out_load = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      op_r        <= OP_CLEAR;
    end else begin
      if (ctl.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_operation;
            step_r  <= '0;
            state_r <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_r <= (job == J_NONE) ? ST_FINISH : ST_BUSY;
        end
        ST_BUSY: begin
          if (sts.done) begin
            step_r  <= step_r + 3'd1;
            state_r <= ST_ISSUE;
          end
        end
        ST_FINISH: begin
          if (ctl.out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath only finishes a job the controller is waiting on
  a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> state_r == ST_BUSY)
    else $error("datapath done outside busy state");

  a_accept_issue: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_ISSUE)
    else $error("accepted command did not start issuing");

  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> (!out_valid_r || !out_stall))
    else $error("result overwritten while stalled");

endmodule

// ===== design/fbde_dp.sv =====
module fbde_dp #(
  parameter int FB_WIDTH  = fbde_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fbde_pkg::FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fbde_pkg::ctl_t     ctl,
  output fbde_pkg::sts_t     sts,
  input  logic signed [11:0] in_xa,
  input  logic signed [11:0] in_ya,
  input  logic signed [11:0] in_xb,
  input  logic signed [11:0] in_yb,
  input  logic [7:0]         in_color,
  input  logic [7:0]         in_fill_color,
  output logic [7:0]         out_pixel_value
);
  import fbde_pkg::*;

  localparam int XW = $clog2(FB_WIDTH);
  localparam int YW = $clog2(FB_HEIGHT);
  localparam int AW = $clog2(FB_WIDTH * FB_HEIGHT);

  typedef enum logic [2:0] {
    M_IDLE,
    M_BOX,
    M_LSET,
    M_LINE,
    M_READ,
    M_RDWAIT
  } mode_t;

  mode_t             mode_r;
  logic              done_r;
  logic signed [11:0] xa_r, ya_r, xb_r, yb_r;
  logic [7:0]        color_r, fc_r, colr_r, pix_r, out_pix_r;
  coord_t            x_r, y_r, xs_r, xe_r, ye_r;
  coord_t            dx_r, dy_r, sx_r, sy_r, e_r, dx2_r, dy2_r;
  logic              swap_r;
  logic [13:0]       cnt_r;

  // box setup
  coord_t bx, by, bw, bh, x0, x1, y0, y1, va, vb, vlo, vhi;
  coord_t xs, xe, ys, ye;
  logic   empty;
  // line setup and step
  coord_t lx1, adx, ady, amaj, amin, xn, yn, en;
  logic   lswap;
  // memory access
  coord_t          cx, cy;
  logic            cur_in;
  logic [AW-1:0]   addr;
  logic            ram_en, ram_we;
  logic [7:0]      rdata;

  function automatic logic in_fb(coord_t x, coord_t y);
    return x >= 0 && x < coord_t'(FB_WIDTH) && y >= 0 && y < coord_t'(FB_HEIGHT);
  endfunction

  always_comb begin
    if (ctl.sel == J_INNER) begin
      bx = coord_t'(xa_r) + coord_t'(1);
      by = coord_t'(ya_r) + coord_t'(1);
      bw = coord_t'(xb_r) - coord_t'(2);
      bh = coord_t'(yb_r) - coord_t'(2);
    end else begin
      bx = coord_t'(xa_r);
      by = coord_t'(ya_r);
      bw = coord_t'(xb_r);
      bh = coord_t'(yb_r);
    end
    if (ctl.sel == J_VSPAN) begin
      va = coord_t'(ya_r);
      vb = coord_t'(yb_r);
    end else begin
      va = by;
      vb = by + bh;
    end
    vlo = (va < vb) ? va : vb;
    vhi = ((va < vb) ? vb : va) - coord_t'(1);
    x0 = bx;
    x1 = bx + bw;
    y0 = by;
    y1 = by + bh;
    case (ctl.sel)
      J_CLEAR: begin
        x0 = '0;
        x1 = coord_t'(FB_WIDTH - 1);
        y0 = '0;
        y1 = coord_t'(FB_HEIGHT - 1);
      end
      J_POINT: begin
        x0 = coord_t'(xa_r);
        x1 = coord_t'(xa_r);
        y0 = coord_t'(ya_r);
        y1 = coord_t'(ya_r);
      end
      J_HSPAN: begin
        x0 = coord_t'(xa_r);
        x1 = coord_t'(xb_r);
        y0 = coord_t'(ya_r);
        y1 = coord_t'(ya_r);
      end
      J_VSPAN: begin
        x0 = coord_t'(xa_r);
        x1 = coord_t'(xa_r);
        y0 = vlo;
        y1 = vhi;
      end
      J_TOP: begin
        y1 = by;
      end
      J_BOT: begin
        y0 = by + bh;
      end
      J_LEFT: begin
        x1 = bx;
        y0 = vlo;
        y1 = vhi;
      end
      J_RIGHT: begin
        x0 = bx + bw;
        y0 = vlo;
        y1 = vhi;
      end
      default: begin
      end
    endcase
    xs    = (x0 < 0) ? coord_t'(0) : x0;
    xe    = (x1 > coord_t'(FB_WIDTH - 1)) ? coord_t'(FB_WIDTH - 1) : x1;
    ys    = (y0 < 0) ? coord_t'(0) : y0;
    ye    = (y1 > coord_t'(FB_HEIGHT - 1)) ? coord_t'(FB_HEIGHT - 1) : y1;
    empty = (xs > xe) || (ys > ye);
  end

  always_comb begin
    // zero-length line starts one pixel to the right
    lx1   = coord_t'(xa_r) + ((xa_r == xb_r && ya_r == yb_r) ? coord_t'(1) : coord_t'(0));
    adx   = (dx_r < 0) ? -dx_r : dx_r;
    ady   = (dy_r < 0) ? -dy_r : dy_r;
    lswap = ady > adx;
    amaj  = lswap ? ady : adx;
    amin  = lswap ? adx : ady;
    xn    = x_r;
    yn    = y_r;
    en    = e_r + dy2_r;
    if (e_r >= 0) begin
      en = e_r + dy2_r - dx2_r;
      if (swap_r) begin
        xn = x_r + sx_r;
      end else begin
        yn = y_r + sy_r;
      end
    end
    if (swap_r) begin
      yn = yn + sy_r;
    end else begin
      xn = xn + sx_r;
    end
  end

  always_comb begin
    if (mode_r == M_READ) begin
      cx = coord_t'(xa_r);
      cy = coord_t'(ya_r);
    end else begin
      cx = x_r;
      cy = y_r;
    end
    cur_in = in_fb(cx, cy);
    addr   = AW'(cy[YW-1:0]) * AW'(FB_WIDTH) + AW'(cx[XW-1:0]);
    ram_we = (mode_r == M_BOX) || ((mode_r == M_LINE) && cur_in);
    ram_en = ram_we || ((mode_r == M_READ) && cur_in);
  end

  fbde_ram #(
    .DATA_W (8),
    .DEPTH  (FB_WIDTH * FB_HEIGHT)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (addr),
    .wdata (colr_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (mode_r)
        M_IDLE: begin
          if (ctl.start) begin
            if (ctl.sel == J_LINE) begin
              mode_r <= M_LSET;
            end else if (ctl.sel == J_READ) begin
              mode_r <= M_READ;
            end else if (empty) begin
              done_r <= 1'b1;
            end else begin
              mode_r <= M_BOX;
            end
          end
        end
        M_BOX: begin
          if (x_r == xe_r && y_r == ye_r) begin
            mode_r <= M_IDLE;
            done_r <= 1'b1;
          end
        end
        M_LSET: mode_r <= M_LINE;
        M_LINE: begin
          if (cnt_r == '0) begin
            mode_r <= M_IDLE;
            done_r <= 1'b1;
          end
        end
        M_READ: mode_r <= M_RDWAIT;
        M_RDWAIT: begin
          mode_r <= M_IDLE;
          done_r <= 1'b1;
        end
        default: mode_r <= M_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      xa_r    <= in_xa;
      ya_r    <= in_ya;
      xb_r    <= in_xb;
      yb_r    <= in_yb;
      color_r <= in_color;
      fc_r    <= in_fill_color;
      pix_r   <= '0;
    end
    if (ctl.out_load) begin
      out_pix_r <= pix_r;
    end
    case (mode_r)
      M_IDLE: begin
        if (ctl.start) begin
          colr_r <= (ctl.sel == J_INNER) ? fc_r : color_r;
          if (ctl.sel == J_LINE) begin
            x_r  <= lx1;
            y_r  <= coord_t'(ya_r);
            dx_r <= coord_t'(xb_r) - lx1;
            dy_r <= coord_t'(yb_r) - coord_t'(ya_r);
          end else begin
            x_r  <= xs;
            y_r  <= ys;
            xs_r <= xs;
            xe_r <= xe;
            ye_r <= ye;
          end
        end
      end
      M_BOX: begin
        if (x_r == xe_r) begin
          x_r <= xs_r;
          y_r <= y_r + coord_t'(1);
        end else begin
          x_r <= x_r + coord_t'(1);
        end
      end
      M_LSET: begin
        sx_r   <= (dx_r > 0) ? coord_t'(1) : ((dx_r < 0) ? coord_t'(-1) : coord_t'(0));
        sy_r   <= (dy_r > 0) ? coord_t'(1) : ((dy_r < 0) ? coord_t'(-1) : coord_t'(0));
        swap_r <= lswap;
        e_r    <= (amin <<< 1) - amaj;
        dx2_r  <= amaj <<< 1;
        dy2_r  <= amin <<< 1;
        cnt_r  <= amaj[13:0];
      end
      M_LINE: begin
        x_r   <= xn;
        y_r   <= yn;
        e_r   <= en;
        cnt_r <= cnt_r - 14'd1;
      end
      M_RDWAIT: begin
        pix_r <= in_fb(coord_t'(xa_r), coord_t'(ya_r)) ? rdata : 8'd0;
      end
      default: begin
      end
    endcase
  end

  assign sts.done        = done_r;
  assign out_pixel_value = out_pix_r;

  // clamped box walk never leaves the buffer
  a_box_inside: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == M_BOX |-> in_fb(x_r, y_r))
    else $error("box walk outside buffer");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> mode_r == M_IDLE)
    else $error("done raised while still walking");

endmodule

// ===== design/framebuffer_draw_engine.sv =====
// framebuffer draw engine: clears, draws points, spans, Bresenham lines and rectangles
// into an 8-bit palette-index frame store of FB_WIDTH x FB_HEIGHT pixels, or
// reads one pixel back.
// input channel: in_valid/in_stall with the command fields; one command is
// taken at a time, in_stall stays high until its result is queued.
// result channel: out_valid/out_stall carrying out_pixel_value, one beat per
// command (the pixel for a read, zero otherwise). the result sits in an output
// register, so the next command is taken while that beat is still stalled.
// each drawing job first sets up its span (a line through a further setup
// step), then writes its pixels, then the result is queued; the single frame
// store port writes one pixel a cycle.
// reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; the frame store keeps no reset value, so issue a clear before the
// first read. a stalled receiver only holds the finished result; a command
// already accepted completes its drawing first.
module framebuffer_draw_engine #(
  parameter int FB_WIDTH  = fbde_pkg::FB_WIDTH_DEF,
  parameter int FB_HEIGHT = fbde_pkg::FB_HEIGHT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_operation,
  input  logic signed [11:0] in_xa,
  input  logic signed [11:0] in_ya,
  input  logic signed [11:0] in_xb,
  input  logic signed [11:0] in_yb,
  input  logic [7:0]         in_color,
  input  logic [7:0]         in_fill_color,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_pixel_value
);
  import fbde_pkg::*;

  ctl_t ctl;
  sts_t sts;

  fbde_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .ctl          (ctl),
    .sts          (sts)
  );

  fbde_dp #(
    .FB_WIDTH  (FB_WIDTH),
    .FB_HEIGHT (FB_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .sts             (sts),
    .in_xa           (in_xa),
    .in_ya           (in_ya),
    .in_xb           (in_xb),
    .in_yb           (in_yb),
    .in_color        (in_color),
    .in_fill_color   (in_fill_color),
    .out_pixel_value (out_pixel_value)
  );

endmodule
